[design/stcsc_pkg.sv]
package stcsc_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int MAX_DIM = 1024;

  localparam int ROW_W = 10;
  localparam int COL_W = 10;
  localparam int VAL_W = 64;
  localparam int OP_W = 3;
  localparam int STATUS_W = 2;
  localparam int IDX_W = 11;
  localparam int LIMIT_W = 11;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
  localparam int DIM_AW = $clog2(MAX_DIM);
  localparam int START_AW = $clog2(MAX_DIM + 1);
  localparam int CFG_IDX_W = 1;

  localparam int ENTRY_W = ROW_W + COL_W + VAL_W;
  localparam int PACKED_W = ROW_W + VAL_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD         = 3'd0,
    OP_INSERT      = 3'd1,
    OP_REMOVE      = 3'd2,
    OP_GET         = 3'd3,
    OP_COMPRESS    = 3'd4,
    OP_READ_START  = 3'd5,
    OP_READ_PACKED = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_LIMIT = 1'b1;

endpackage

[design/stcsc_ram.sv]
module stcsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/sparse_triplet_store_to_csc_core.sv]
// Steps: get scans the stored entries from the last one down; remove scans
// the same way, then moves each later entry down over the removed one; insert
// drops a match that way before it appends; compress sums the column counts
// below the column limit, then places each stored entry in its column.
// Throughput: one transaction at a time; the shared entry-table port sets the pace.
// Reset: a clearing pass zeroes every column count; busy stays high until it ends.
// Results are valid with done, high for one cycle, and hold until the next start; the receiver cannot stall.
module sparse_triplet_store_to_csc_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [stcsc_pkg::OP_W-1:0]          op,
  input  logic [stcsc_pkg::ROW_W-1:0]         row,
  input  logic [stcsc_pkg::COL_W-1:0]         column,
  input  logic [stcsc_pkg::VAL_W-1:0]         value_in,
  input  logic [stcsc_pkg::IDX_W-1:0]         index,
  input  logic                                cfg_we,
  input  logic [stcsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stcsc_pkg::LIMIT_W-1:0]       cfg_data,
  output logic                                done,
  output logic [stcsc_pkg::STATUS_W-1:0]      status,
  output logic [stcsc_pkg::VAL_W-1:0]         value_out,
  output logic [stcsc_pkg::ROW_W-1:0]         row_out,
  output logic [stcsc_pkg::CNT_W-1:0]         count_out
);
  import stcsc_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FIND_RD, S_FIND_CMP, S_AFTER_FIND, S_DEC_RD, S_DEC_WR,
    S_SHIFT_RD, S_SHIFT_WR, S_SHIFT_END, S_ADD, S_INC_RD, S_INC_WR,
    S_PFX_RD, S_PFX_ADD, S_PFX_LAST, S_PK_RD, S_PK_CHK, S_PK_WR,
    S_RD_ISSUE, S_RD_OUT
  } state_t;

  state_t state;

  logic [LIMIT_W-1:0]  row_limit;
  logic [LIMIT_W-1:0]  column_limit;
  logic [CNT_W-1:0]    total;
  logic [CNT_W-1:0]    k;
  logic [START_AW-1:0] j;
  logic [START_AW-1:0] lim;
  logic [CNT_W-1:0]    sum;
  logic [DIM_AW-1:0]   clr;
  logic                hit;
  logic [VAL_W-1:0]    hit_val;
  op_t                 op_r;
  logic [ROW_W-1:0]    row_r;
  logic [COL_W-1:0]    col_r;
  logic [VAL_W-1:0]    val_r;
  logic [IDX_W-1:0]    idx_r;
  logic [ROW_W-1:0]    pk_row;
  logic [VAL_W-1:0]    pk_val;
  logic [COL_W-1:0]    pk_col;

  logic                ent_we;
  logic [ENTRY_AW-1:0] ent_waddr, ent_raddr;
  logic [ENTRY_W-1:0]  ent_wdata, ent_rdata;
  logic                cnt_we;
  logic [DIM_AW-1:0]   cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
  logic                st_we;
  logic [START_AW-1:0] st_waddr, st_raddr;
  logic [CNT_W-1:0]    st_wdata, st_rdata;
  logic                fill_we;
  logic [DIM_AW-1:0]   fill_waddr, fill_raddr;
  logic [CNT_W-1:0]    fill_wdata, fill_rdata;
  logic                pk_we;
  logic [ENTRY_AW-1:0] pk_waddr, pk_raddr;
  logic [PACKED_W-1:0] pk_wdata, pk_rdata;

  logic [ROW_W-1:0]    e_row;
  logic [COL_W-1:0]    e_col;
  logic [VAL_W-1:0]    e_val;
  logic                add_range_bad;
  logic                add_full;
  logic [CNT_W-1:0]    pk_pos;

  function automatic logic [LIMIT_W-1:0] cap_limit(input logic [LIMIT_W-1:0] r);
    return (r > LIMIT_W'(MAX_DIM)) ? LIMIT_W'(MAX_DIM) : r;
  endfunction

  assign e_row = ent_rdata[ENTRY_W-1 -: ROW_W];
  assign e_col = ent_rdata[VAL_W +: COL_W];
  assign e_val = ent_rdata[VAL_W-1:0];

  assign add_range_bad = ({1'b0, row_r} >= cap_limit(row_limit)) ||
                         ({1'b0, col_r} >= cap_limit(column_limit));
  assign add_full = (total >= CNT_W'(MAX_ENTRIES));
  assign pk_pos = st_rdata + fill_rdata;
  assign busy = (state != S_IDLE);

  always_comb begin
    ent_we = 1'b0;
    ent_waddr = k[ENTRY_AW-1:0];
    ent_wdata = ent_rdata;
    ent_raddr = k[ENTRY_AW-1:0];
    cnt_we = 1'b0;
    cnt_waddr = col_r;
    cnt_wdata = '0;
    cnt_raddr = col_r;
    st_we = 1'b0;
    st_waddr = j;
    st_wdata = sum;
    st_raddr = idx_r;
    fill_we = 1'b0;
    fill_waddr = j[DIM_AW-1:0];
    fill_wdata = '0;
    fill_raddr = e_col;
    pk_we = 1'b0;
    pk_waddr = pk_pos[ENTRY_AW-1:0];
    pk_wdata = {pk_row, pk_val};
    pk_raddr = idx_r[ENTRY_AW-1:0];
    unique case (state)
      S_CLEAR: begin
        cnt_we = 1'b1;
        cnt_waddr = clr;
      end
      S_DEC_WR: begin
        cnt_we = (cnt_rdata != '0);
        cnt_wdata = cnt_rdata - 1'b1;
      end
      S_SHIFT_RD: begin
        ent_raddr = ENTRY_AW'(k + 1'b1);
      end
      S_SHIFT_WR: begin
        ent_we = 1'b1;
      end
      S_ADD: begin
        ent_we = !add_range_bad && !add_full;
        ent_waddr = total[ENTRY_AW-1:0];
        ent_wdata = {row_r, col_r, val_r};
      end
      S_INC_WR: begin
        cnt_we = 1'b1;
        cnt_wdata = cnt_rdata + 1'b1;
      end
      S_PFX_RD: begin
        cnt_raddr = j[DIM_AW-1:0];
        st_we = 1'b1;
        fill_we = 1'b1;
      end
      S_PFX_LAST: begin
        st_we = 1'b1;
        st_waddr = lim;
      end
      S_PK_CHK: begin
        st_raddr = START_AW'(e_col);
      end
      S_PK_WR: begin
        pk_we = (pk_pos < CNT_W'(MAX_ENTRIES));
        fill_we = 1'b1;
        fill_waddr = pk_col;
        fill_wdata = fill_rdata + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      total <= '0;
      done <= 1'b0;
      row_limit <= LIMIT_W'(MAX_DIM);
      column_limit <= LIMIT_W'(MAX_DIM);
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_ROW_LIMIT) begin
          row_limit <= cfg_data;
        end else begin
          column_limit <= cfg_data;
        end
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r <= op_t'(op);
            row_r <= row;
            col_r <= column;
            val_r <= value_in;
            idx_r <= index;
            status <= ST_OK;
            value_out <= '0;
            row_out <= '0;
            count_out <= '0;
            hit <= 1'b0;
            case (op_t'(op))
              OP_ADD: begin
                state <= S_ADD;
              end
              OP_INSERT, OP_REMOVE, OP_GET: begin
                k <= total - 1'b1;
                state <= (total == '0) ? S_AFTER_FIND : S_FIND_RD;
              end
              OP_COMPRESS: begin
                lim <= START_AW'(cap_limit(column_limit));
                j <= '0;
                sum <= '0;
                state <= (cap_limit(column_limit) == '0) ? S_PFX_LAST : S_PFX_RD;
              end
              OP_READ_START: begin
                if (index > IDX_W'(MAX_DIM)) begin
                  status <= ST_RANGE;
                  done <= 1'b1;
                end else begin
                  state <= S_RD_ISSUE;
                end
              end
              OP_READ_PACKED: begin
                if (index >= IDX_W'(MAX_ENTRIES)) begin
                  status <= ST_RANGE;
                  done <= 1'b1;
                end else begin
                  state <= S_RD_ISSUE;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_FIND_RD: begin
          state <= S_FIND_CMP;
        end
        S_FIND_CMP: begin
          if (e_row == row_r && e_col == col_r) begin
            hit <= 1'b1;
            hit_val <= e_val;
            state <= S_AFTER_FIND;
          end else if (k == '0) begin
            state <= S_AFTER_FIND;
          end else begin
            k <= k - 1'b1;
            state <= S_FIND_RD;
          end
        end
        S_AFTER_FIND: begin
          if (op_r == OP_GET) begin
            if (hit) begin
              value_out <= hit_val;
            end else begin
              status <= ST_NOT_FOUND;
            end
            done <= 1'b1;
            state <= S_IDLE;
          end else if (hit) begin
            state <= S_DEC_RD;
          end else if (op_r == OP_REMOVE) begin
            status <= ST_NOT_FOUND;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_ADD;
          end
        end
        S_DEC_RD: begin
          state <= S_DEC_WR;
        end
        S_DEC_WR: begin
          state <= (CNT_W'(k + 1'b1) < total) ? S_SHIFT_RD : S_SHIFT_END;
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          k <= k + 1'b1;
          state <= (CNT_W'(k + 2'd2) < total) ? S_SHIFT_RD : S_SHIFT_END;
        end
        S_SHIFT_END: begin
          total <= total - 1'b1;
          if (op_r == OP_REMOVE) begin
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (add_range_bad) begin
            status <= ST_RANGE;
            done <= 1'b1;
            state <= S_IDLE;
          end else if (add_full) begin
            status <= ST_FULL;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            total <= total + 1'b1;
            state <= S_INC_RD;
          end
        end
        S_INC_RD: begin
          state <= S_INC_WR;
        end
        S_INC_WR: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_PFX_RD: begin
          state <= S_PFX_ADD;
        end
        S_PFX_ADD: begin
          sum <= sum + cnt_rdata;
          j <= j + 1'b1;
          state <= (START_AW'(j + 1'b1) == lim) ? S_PFX_LAST : S_PFX_RD;
        end
        S_PFX_LAST: begin
          count_out <= sum;
          k <= total - 1'b1;
          if (total == '0) begin
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_PK_RD;
          end
        end
        S_PK_RD: begin
          state <= S_PK_CHK;
        end
        S_PK_CHK: begin
          if (START_AW'(e_col) < lim) begin
            pk_row <= e_row;
            pk_val <= e_val;
            pk_col <= e_col;
            state <= S_PK_WR;
          end else if (k == '0) begin
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            k <= k - 1'b1;
            state <= S_PK_RD;
          end
        end
        S_PK_WR: begin
          if (k == '0) begin
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            k <= k - 1'b1;
            state <= S_PK_RD;
          end
        end
        S_RD_ISSUE: begin
          state <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (op_r == OP_READ_START) begin
            count_out <= st_rdata;
          end else begin
            row_out <= pk_rdata[PACKED_W-1 -: ROW_W];
            value_out <= pk_rdata[VAL_W-1:0];
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  stcsc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_entries (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  stcsc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DIM)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  stcsc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DIM + 1)) u_starts (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  stcsc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DIM)) u_fill (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .raddr(fill_raddr), .rdata(fill_rdata)
  );

  stcsc_ram #(.WIDTH(PACKED_W), .DEPTH(MAX_ENTRIES)) u_packed (
    .clk(clk), .we(pk_we), .waddr(pk_waddr), .wdata(pk_wdata),
    .raddr(pk_raddr), .rdata(pk_rdata)
  );

endmodule
